[hw/rtl/mfae_pkg.sv]
// Shared widths, register indexes and the multiply-accumulate control type
// for the feedback acceleration estimator. No dependencies.
`default_nettype none

package mfae_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_OFS   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRQ_CONST = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B0   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B1   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B2   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A1   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A2   = 4'd7;

  // payload widths
  localparam int FRAME_W = 64;
  localparam int POS_W   = 27;
  localparam int POFS_W  = 28;
  localparam int VEL_W   = 29;
  localparam int CUR_W   = 23;
  localparam int TRQ_W   = 27;
  localparam int ACC_W   = 40;
  localparam int TEMP_W  = 8;
  localparam int ERR_W   = 8;

  // register widths
  localparam int OFS_W  = 27;
  localparam int KT_W   = 20;
  localparam int COEF_W = 32;

  // shared multiplier and accumulator
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 21;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int SUM_W   = 75;
  localparam int PART_W  = 20;

  // accumulator control, one word per cycle from the sequencer
  typedef struct packed {
    logic clr;
    logic en;
    logic sub;
    logic shift;
  } mac_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/mfae_if.sv]
// Request channels of the feedback acceleration estimator: the frame input
// and the decoded result output. Depends on mfae_pkg.
`default_nettype none

interface mfae_in_if;
  import mfae_pkg::*;
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] frame_data;

  modport source (output valid, output frame_data, input ready);
  modport sink (input valid, input frame_data, output ready);
endinterface

interface mfae_out_if;
  import mfae_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  position_deg;
  logic signed [POFS_W-1:0] position_rel_deg;
  logic signed [VEL_W-1:0]  velocity_dps;
  logic signed [CUR_W-1:0]  current_amp;
  logic signed [TRQ_W-1:0]  torque_nm;
  logic signed [ACC_W-1:0]  accel_raw;
  logic signed [ACC_W-1:0]  accel_filtered;
  logic signed [TEMP_W-1:0] temperature;
  logic [ERR_W-1:0]         error_code;

  modport source (
    output valid, output position_deg, output position_rel_deg, output velocity_dps,
    output current_amp, output torque_nm, output accel_raw, output accel_filtered,
    output temperature, output error_code, input ready
  );
  modport sink (
    input valid, input position_deg, input position_rel_deg, input velocity_dps,
    input current_amp, input torque_nm, input accel_raw, input accel_filtered,
    input temperature, input error_code, output ready
  );
endinterface

`default_nettype wire

[hw/rtl/mfae_mac.sv]
// Shared 32x21 signed multiplier with registered product and a wide
// accumulator that adds or subtracts the product, optionally shifted by 20.
// Depends on mfae_pkg.
`default_nettype none

module mfae_mac import mfae_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic signed [MUL_A_W-1:0] a_i,
  input  wire logic signed [MUL_B_W-1:0] b_i,
  input  wire mac_ctrl_t                 ctrl_i,
  output logic signed [PROD_W-1:0]       prod_o,
  output logic signed [SUM_W-1:0]        sum_o
);

  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [SUM_W-1:0]  sum_d;
  logic signed [SUM_W-1:0]  term_ext;
  logic signed [SUM_W-1:0]  term;

  // one product per cycle
  assign prod_d = a_i * b_i;

  // align the previous product and accumulate
  always_comb begin
    term_ext = SUM_W'(prod_q);
    term     = ctrl_i.shift ? (term_ext <<< PART_W) : term_ext;
    if (ctrl_i.clr) begin
      sum_d = '0;
    end else if (ctrl_i.en) begin
      sum_d = ctrl_i.sub ? (sum_q - term) : (sum_q + term);
    end else begin
      sum_d = sum_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    sum_q  <= sum_d;
  end

  assign prod_o = prod_q;
  assign sum_o  = sum_q;

endmodule

`default_nettype wire

[hw/rtl/mit_feedback_accel_estimator_core.sv]
// Feedback frame decoder and acceleration estimator, top level.
// Depends on mfae_pkg, mfae_if and mfae_mac.
//
// Usage: one 64-bit feedback frame enters on frame_i (byte 0 in bits 63..56)
// and one result leaves on result_o: position, offset position, velocity,
// current, torque, raw and filtered acceleration, temperature and error code.
// Registers are written through cfg_we_i / cfg_idx_i / cfg_data_i; the user
// must write them only while the block is idle, which the block itself does
// not enforce; indexes above 7 are ignored. One item at a time: frame_i.ready
// is high only while the sequencer is idle, so a new frame is taken only once
// the last result has been handed off. Steps in order: decode (DEC1, DEC2),
// the shared multiplier for acceleration and torque (MACC, MTRQ), then ten
// passes of the filter sum over the same multiplier (one coefficient half a
// cycle), one more to drain the accumulator, rounding (RND), hand-off (DONE).
// The result sits in an output register; the next frame is accepted while it
// waits, and that frame's result is held back until the register is free.
// Reset clears registers, velocity and filter history to zero.
`default_nettype none

module mit_feedback_accel_estimator_core import mfae_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  mfae_in_if.sink                    frame_i,
  mfae_out_if.source                 result_o
);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DEC1 = 3'd1;
  localparam logic [2:0] ST_DEC2 = 3'd2;
  localparam logic [2:0] ST_MACC = 3'd3;
  localparam logic [2:0] ST_MTRQ = 3'd4;
  localparam logic [2:0] ST_FIR  = 3'd5;
  localparam logic [2:0] ST_RND  = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  // filter passes: five taps, two halves each, plus one drain pass
  localparam logic [3:0] FIR_LAST = 4'd10;

  localparam logic signed [POFS_W-1:0] POFS_LIM  = 28'sd94380000;
  localparam logic [35:0]              TRQ_LIM   = 36'd39350000;
  localparam logic signed [PROD_W-1:0] ACC_LIM_P = 53'sd400000000000;
  localparam logic signed [44:0]       ACC_LIM_S = 45'sd400000000000;
  localparam logic signed [SUM_W-1:0]  RND_HALF  = 75'sd536870912;

  // configuration registers
  logic                     rev_q;
  logic signed [OFS_W-1:0]  ofs_q;
  logic [KT_W-1:0]          kt_q;
  logic signed [COEF_W-1:0] b0_q, b1_q, b2_q, a1_q, a2_q;

  // control and filter state
  logic [2:0]              state_q, state_d;
  logic [3:0]              cnt_q, cnt_d;
  logic                    out_valid_q, out_valid_d;
  logic                    load;
  logic signed [VEL_W-1:0] last_vel_q;
  logic signed [ACC_W-1:0] raw1_q, raw2_q, filt1_q, filt2_q;

  // datapath registers
  logic [FRAME_W-1:0]       frame_q;
  logic [25:0]              pn_q;
  logic                     pneg_q;
  logic [21:0]              cn_q;
  logic                     cneg_q;
  logic signed [VEL_W-1:0]  vel_q;
  logic signed [POS_W-1:0]  pos_q;
  logic signed [CUR_W-1:0]  cur_q;
  logic signed [29:0]       diff_q;
  logic signed [POFS_W-1:0] pofs_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [TRQ_W-1:0]  trq_q;
  logic signed [ACC_W-1:0]  filt_q;

  // output register
  logic signed [POS_W-1:0]  o_pos_q;
  logic signed [POFS_W-1:0] o_pofs_q;
  logic signed [VEL_W-1:0]  o_vel_q;
  logic signed [CUR_W-1:0]  o_cur_q;
  logic signed [TRQ_W-1:0]  o_trq_q;
  logic signed [ACC_W-1:0]  o_acc_q;
  logic signed [ACC_W-1:0]  o_filt_q;
  logic signed [TEMP_W-1:0] o_temp_q;
  logic [ERR_W-1:0]         o_err_q;

  // shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  mac_ctrl_t                 mac_ctrl;
  logic signed [PROD_W-1:0]  prod;
  logic signed [SUM_W-1:0]   sum;

  mfae_mac u_mac (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .ctrl_i (mac_ctrl),
    .prod_o (prod),
    .sum_o  (sum)
  );

  // first decode step: code offsets, magnitudes and constant gains
  logic [15:0]             p_code;
  logic [11:0]             v_code, i_code;
  logic signed [16:0]      pd;
  logic [15:0]             pabs;
  logic signed [12:0]      cd;
  logic [11:0]             cabs;
  logic signed [12:0]      vd, vds;
  logic [25:0]             pn_d;
  logic [21:0]             cn_d;
  logic signed [VEL_W-1:0] vel_d;

  always_comb begin
    p_code = frame_q[55:40];
    v_code = frame_q[39:28];
    i_code = frame_q[27:16];
    pd     = signed'({1'b0, p_code}) - 17'sd32767;
    pabs   = pd[16] ? 16'(-pd) : 16'(pd);
    cd     = signed'({1'b0, i_code}) - 13'sd2048;
    cabs   = cd[12] ? 12'(-cd) : 12'(cd);
    vd     = signed'({1'b0, v_code}) - 13'sd2047;
    vds    = rev_q ? -vd : vd;
    pn_d   = 26'(pabs) * 26'd1440;
    cn_d   = 22'(cabs) * 22'd1920;
    vel_d  = vds * 29'sd92160;
  end

  // second decode step: divide by 2^15-1 and 2^11-1 with rounding
  logic [25:0]             xp, pmag;
  logic [10:0]             ap, qp;
  logic [14:0]             bp;
  logic [15:0]             tp;
  logic [21:0]             xc, cmag;
  logic [10:0]             ac, qc;
  logic [11:0]             tc;
  logic signed [POS_W-1:0] pmag_s, pos_d;
  logic signed [CUR_W-1:0] cmag_s, cur_d;
  logic signed [29:0]      diff_d;

  always_comb begin
    xp     = pn_q + 26'd16383;
    ap     = xp[25:15];
    bp     = xp[14:0];
    tp     = {5'b0, ap} + {1'b0, bp};
    qp     = ap + 11'(tp >= 16'd32767);
    pmag   = pn_q + 26'(qp);
    pmag_s = signed'({1'b0, pmag});
    pos_d  = pneg_q ? -pmag_s : pmag_s;
    xc     = cn_q + 22'd1023;
    ac     = xc[21:11];
    tc     = {1'b0, ac} + {1'b0, xc[10:0]};
    qc     = ac + 11'(tc >= 12'd2047);
    cmag   = cn_q + 22'(qc);
    cmag_s = signed'({1'b0, cmag});
    cur_d  = cneg_q ? -cmag_s : cmag_s;
    diff_d = 30'(vel_q) - 30'(last_vel_q);
  end

  // offset position with saturation
  logic signed [POFS_W-1:0] pdiff, pofs_d;

  always_comb begin
    pdiff = POFS_W'(pos_q) - POFS_W'(ofs_q);
    if (pdiff > POFS_LIM) begin
      pofs_d = POFS_LIM;
    end else if (pdiff < -POFS_LIM) begin
      pofs_d = -POFS_LIM;
    end else begin
      pofs_d = pdiff;
    end
  end

  // raw acceleration from the product of the velocity step and 1000
  logic signed [ACC_W-1:0] acc_d;

  always_comb begin
    if (prod > ACC_LIM_P) begin
      acc_d = ACC_W'(ACC_LIM_P);
    end else if (prod < -ACC_LIM_P) begin
      acc_d = ACC_W'(-ACC_LIM_P);
    end else begin
      acc_d = ACC_W'(prod);
    end
  end

  // torque: round the current times constant product by 2^16, saturate
  logic                    tneg;
  logic [PROD_W-2:0]       tabs;
  logic [35:0]             tr, tcl;
  logic signed [TRQ_W-1:0] tmag_s, trq_d;

  always_comb begin
    tneg   = prod[PROD_W-1];
    tabs   = tneg ? (PROD_W-1)'(-prod) : (PROD_W-1)'(prod);
    tr     = 36'((tabs + 52'd32768) >> 16);
    tcl    = (tr > TRQ_LIM) ? TRQ_LIM : tr;
    tmag_s = signed'(TRQ_W'(tcl));
    trq_d  = tneg ? -tmag_s : tmag_s;
  end

  // filter output: round half up by 2^30, saturate
  logic signed [44:0]      sr;
  logic signed [ACC_W-1:0] filt_d;

  always_comb begin
    sr = 45'((sum + RND_HALF) >>> 30);
    if (sr > ACC_LIM_S) begin
      filt_d = ACC_W'(ACC_LIM_S);
    end else if (sr < -ACC_LIM_S) begin
      filt_d = ACC_W'(-ACC_LIM_S);
    end else begin
      filt_d = ACC_W'(sr);
    end
  end

  // multiplier operand selection and accumulator control
  logic [2:0]               tap;
  logic [3:0]               step;
  logic signed [COEF_W-1:0] coef_sel;
  logic signed [ACC_W-1:0]  x_sel;

  always_comb begin
    tap  = cnt_q[3:1];
    step = cnt_q - 4'd1;
    case (tap)
      3'd0:    begin coef_sel = b0_q; x_sel = acc_q;   end
      3'd1:    begin coef_sel = b1_q; x_sel = raw1_q;  end
      3'd2:    begin coef_sel = b2_q; x_sel = raw2_q;  end
      3'd3:    begin coef_sel = a1_q; x_sel = filt1_q; end
      3'd4:    begin coef_sel = a2_q; x_sel = filt2_q; end
      default: begin coef_sel = '0;   x_sel = '0;      end
    endcase

    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_MACC: begin
        mul_a = MUL_A_W'(diff_q);
        mul_b = 21'sd1000;
      end
      ST_MTRQ: begin
        mul_a = MUL_A_W'(cur_q);
        mul_b = signed'({1'b0, kt_q});
      end
      ST_FIR: begin
        mul_a = coef_sel;
        mul_b = cnt_q[0] ? MUL_B_W'(signed'(x_sel[ACC_W-1:PART_W]))
                         : signed'({1'b0, x_sel[PART_W-1:0]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase

    mac_ctrl.clr   = (state_q == ST_FIR) && (cnt_q == 4'd0);
    mac_ctrl.en    = (state_q == ST_FIR) && (cnt_q != 4'd0);
    mac_ctrl.sub   = step[3:1] >= 3'd3;
    mac_ctrl.shift = step[0];
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    load        = (state_q == ST_DONE) && (!out_valid_q || result_o.ready);
    out_valid_d = out_valid_q && !result_o.ready;
    if (load) begin
      out_valid_d = 1'b1;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (frame_i.valid) begin
          state_d = ST_DEC1;
        end
      end
      ST_DEC1: state_d = ST_DEC2;
      ST_DEC2: state_d = ST_MACC;
      ST_MACC: state_d = ST_MTRQ;
      ST_MTRQ: begin
        state_d = ST_FIR;
        cnt_d   = '0;
      end
      ST_FIR: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == FIR_LAST) begin
          state_d = ST_RND;
        end
      end
      ST_RND: state_d = ST_DONE;
      ST_DONE: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control, configuration and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      rev_q       <= 1'b0;
      ofs_q       <= '0;
      kt_q        <= '0;
      b0_q        <= '0;
      b1_q        <= '0;
      b2_q        <= '0;
      a1_q        <= '0;
      a2_q        <= '0;
      last_vel_q  <= '0;
      raw1_q      <= '0;
      raw2_q      <= '0;
      filt1_q     <= '0;
      filt2_q     <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_REVERSE:   rev_q <= cfg_data_i[0];
          REG_POS_OFS:   ofs_q <= signed'(cfg_data_i[OFS_W-1:0]);
          REG_TRQ_CONST: kt_q  <= cfg_data_i[KT_W-1:0];
          REG_COEF_B0:   b0_q  <= signed'(cfg_data_i[COEF_W-1:0]);
          REG_COEF_B1:   b1_q  <= signed'(cfg_data_i[COEF_W-1:0]);
          REG_COEF_B2:   b2_q  <= signed'(cfg_data_i[COEF_W-1:0]);
          REG_COEF_A1:   a1_q  <= signed'(cfg_data_i[COEF_W-1:0]);
          REG_COEF_A2:   a2_q  <= signed'(cfg_data_i[COEF_W-1:0]);
          default: ;
        endcase
      end
      if (load) begin
        last_vel_q <= vel_q;
        raw2_q     <= raw1_q;
        raw1_q     <= acc_q;
        filt2_q    <= filt1_q;
        filt1_q    <= filt_q;
      end
    end
  end

  // datapath and output payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && frame_i.valid) begin
      frame_q <= frame_i.frame_data;
    end
    if (state_q == ST_DEC1) begin
      pn_q   <= pn_d;
      pneg_q <= pd[16] ^ rev_q;
      cn_q   <= cn_d;
      cneg_q <= cd[12] ^ rev_q;
      vel_q  <= vel_d;
    end
    if (state_q == ST_DEC2) begin
      pos_q  <= pos_d;
      cur_q  <= cur_d;
      diff_q <= diff_d;
    end
    if (state_q == ST_MACC) begin
      pofs_q <= pofs_d;
    end
    if (state_q == ST_MTRQ) begin
      acc_q <= acc_d;
    end
    if (state_q == ST_FIR && cnt_q == 4'd0) begin
      trq_q <= trq_d;
    end
    if (state_q == ST_RND) begin
      filt_q <= filt_d;
    end
    if (load) begin
      o_pos_q  <= pos_q;
      o_pofs_q <= pofs_q;
      o_vel_q  <= vel_q;
      o_cur_q  <= cur_q;
      o_trq_q  <= trq_q;
      o_acc_q  <= acc_q;
      o_filt_q <= filt_q;
      o_temp_q <= signed'(frame_q[15:8]);
      o_err_q  <= frame_q[7:0];
    end
  end

  // channel outputs
  assign frame_i.ready             = (state_q == ST_IDLE);
  assign result_o.valid            = out_valid_q;
  assign result_o.position_deg     = o_pos_q;
  assign result_o.position_rel_deg = o_pofs_q;
  assign result_o.velocity_dps     = o_vel_q;
  assign result_o.current_amp      = o_cur_q;
  assign result_o.torque_nm        = o_trq_q;
  assign result_o.accel_raw        = o_acc_q;
  assign result_o.accel_filtered   = o_filt_q;
  assign result_o.temperature      = o_temp_q;
  assign result_o.error_code       = o_err_q;

endmodule

`default_nettype wire
